FILE: hdl/rbf_pkg.sv
// Shared types, constants and helper functions of the RGB 3x3 box filter.
`default_nettype none

package rbf_pkg;

  localparam int unsigned ChanW    = 8;
  localparam int unsigned PosW     = 12;
  localparam int unsigned DimW     = 13;
  localparam int unsigned ColSumW  = 10;
  localparam int unsigned WinSumW  = 12;
  localparam int unsigned MaxWidth = 4096;
  localparam int unsigned LbAddrW  = $clog2(MaxWidth);
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = $clog2(QDepth);

  localparam logic [DimW-1:0] DimMin       = DimW'(3);
  localparam logic [DimW-1:0] WidthMax     = DimW'(MaxWidth);
  localparam logic [DimW-1:0] HeightMax    = DimW'(4096);
  localparam logic [DimW-1:0] WidthReset   = DimW'(640);
  localparam logic [DimW-1:0] HeightReset  = DimW'(480);

  // 65536 / 9 rounded up; exact floor division for every window sum up to 9 * 255.
  localparam int unsigned RecipBits = 16;
  localparam logic [12:0] Recip9    = 13'd7282;
  localparam int unsigned ProdW     = WinSumW + 13;

  typedef enum logic {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic [ColSumW-1:0] blue;
    logic [ColSumW-1:0] green;
    logic [ColSumW-1:0] red;
  } colsum_t;

  typedef struct packed {
    logic [WinSumW-1:0] blue;
    logic [WinSumW-1:0] green;
    logic [WinSumW-1:0] red;
  } winsum_t;

  // One line-buffer word: the pixels of the two rows above at one column.
  typedef struct packed {
    pixel_t one_back;
    pixel_t two_back;
  } lb_word_t;

  typedef struct packed {
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
    logic            restart;
  } frame_cfg_t;

  typedef struct packed {
    winsum_t        sum;
    pixel_t         px;
    logic [PosW-1:0] row;
    logic [PosW-1:0] col;
    logic           filt;
    logic           bord;
  } qentry_t;

  typedef struct packed {
    logic [PosW-1:0] col;
    logic [PosW-1:0] row;
    pixel_t          px;
  } out_word_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
                                                input logic [DimW-1:0] hi);
    logic [DimW-1:0] r;
    if (v < DimMin) begin
      r = DimMin;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic colsum_t col_sum(input pixel_t a, input pixel_t b, input pixel_t c);
    colsum_t s;
    s.red   = ColSumW'(a.red)   + ColSumW'(b.red)   + ColSumW'(c.red);
    s.green = ColSumW'(a.green) + ColSumW'(b.green) + ColSumW'(c.green);
    s.blue  = ColSumW'(a.blue)  + ColSumW'(b.blue)  + ColSumW'(c.blue);
    return s;
  endfunction

  function automatic winsum_t win_sum(input colsum_t a, input colsum_t b, input colsum_t c);
    winsum_t s;
    s.red   = WinSumW'(a.red)   + WinSumW'(b.red)   + WinSumW'(c.red);
    s.green = WinSumW'(a.green) + WinSumW'(b.green) + WinSumW'(c.green);
    s.blue  = WinSumW'(a.blue)  + WinSumW'(b.blue)  + WinSumW'(c.blue);
    return s;
  endfunction

  function automatic logic [ChanW-1:0] div9(input logic [WinSumW-1:0] s);
    logic [ProdW-1:0] p;
    p = ProdW'(s) * ProdW'(Recip9);
    return p[RecipBits +: ChanW];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/rgb_box_filter_3x3.sv
// Top level of the RGB 3x3 box filter: configuration registers and the three stages.
//
//  Channel  | Direction | Handshake                    | Payload
//  ---------+-----------+------------------------------+--------------------------------------
//  s_axis   | in        | s_axis_tvalid_i/tready_o     | red, green, blue
//  m_axis   | out       | m_axis_tvalid_o/tready_i     | red, green, blue, row, col; tlast
//  cfg      | in        | cfg_valid_i/cfg_ready_o      | index 0 width, 1 height; 13-bit data
//
// One pixel is taken per clock while the queue accepts words. A pixel passes through the
// front-end register and the queue into the output register; an input that yields both a
// filtered center and a border word holds the back end for two output words, which the
// four-word queue absorbs. The rate is set by the single line-buffer memory port pair and
// the one output register. Reset clears position, control and queue state; line buffers
// start unwritten. A configuration write restarts the frame at the same edge. A stalled
// output backs up through the queue into the front end, which then drops s_axis_tready_o.
`default_nettype none

module rgb_box_filter_3x3 (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [23:0] s_axis_tdata_i,   // red_in, green_in, blue_in
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // red_out, green_out, blue_out, out_row, out_col
  output logic        m_axis_tlast_o,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire         cfg_index_i,
  input  wire  [12:0] cfg_data_i
);

  logic [rbf_pkg::DimW-1:0] width_q, height_q;
  rbf_pkg::frame_cfg_t      frame_cfg;
  rbf_pkg::cfg_reg_e        cfg_reg;
  logic                     cfg_wr;

  logic                     push_valid, push_ready, pop_valid, pop_ready;
  rbf_pkg::qentry_t         push_data, pop_data;
  rbf_pkg::out_word_t       out_word;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i & cfg_ready_o;
  assign cfg_reg     = rbf_pkg::cfg_reg_e'(cfg_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= rbf_pkg::WidthReset;
      height_q <= rbf_pkg::HeightReset;
    end else begin
      if (cfg_wr) begin
        case (cfg_reg)
          rbf_pkg::CFG_WIDTH:  width_q  <= rbf_pkg::clamp_dim(cfg_data_i, rbf_pkg::WidthMax);
          rbf_pkg::CFG_HEIGHT: height_q <= rbf_pkg::clamp_dim(cfg_data_i, rbf_pkg::HeightMax);
          default: begin
          end
        endcase
      end
    end
  end

  assign frame_cfg.width   = width_q;
  assign frame_cfg.height  = height_q;
  assign frame_cfg.restart = cfg_wr;

  rbf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (frame_cfg),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_px_i      (rbf_pkg::pixel_t'(s_axis_tdata_i)),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  rbf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  rbf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_data_i   (pop_data),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_data_o   (out_word),
    .out_last_o   (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = out_word;

endmodule

`default_nettype wire

FILE: hdl/rbf_front.sv
// Front end: accepts pixels, tracks position, reads line buffers, forms window sums.
`default_nettype none

module rbf_front (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  rbf_pkg::frame_cfg_t   cfg_i,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  rbf_pkg::pixel_t       in_px_i,
  output logic                  push_valid_o,
  input  wire                   push_ready_i,
  output rbf_pkg::qentry_t      push_data_o
);

  logic [rbf_pkg::PosW-1:0] col_q, col_d, row_q, row_d;
  logic [rbf_pkg::PosW-1:0] wlast, hlast;

  logic                     f1_valid_q;
  rbf_pkg::pixel_t          f1_px_q;
  logic [rbf_pkg::PosW-1:0] f1_col_q, f1_row_q;
  logic                     f1_filt_q, f1_bord_q;
  rbf_pkg::lb_word_t        rd_q;
  rbf_pkg::colsum_t         cs_q [2];
  rbf_pkg::colsum_t         cs_now;

  rbf_pkg::lb_word_t        lb_mem [rbf_pkg::MaxWidth];

  logic accept, f1_needs, f1_adv;
  logic filt_now, bord_now;

  assign wlast = rbf_pkg::PosW'(cfg_i.width - rbf_pkg::DimW'(1));
  assign hlast = rbf_pkg::PosW'(cfg_i.height - rbf_pkg::DimW'(1));

  assign f1_needs     = f1_filt_q | f1_bord_q;
  assign f1_adv       = f1_valid_q & (push_ready_i | ~f1_needs);
  assign in_ready_o   = ~f1_valid_q | f1_adv;
  assign accept       = in_valid_i & in_ready_o;
  assign push_valid_o = f1_valid_q & f1_needs;

  assign filt_now = (row_q >= rbf_pkg::PosW'(2)) && (col_q >= rbf_pkg::PosW'(2));
  assign bord_now = (row_q == '0) || (row_q == hlast) || (col_q == '0) || (col_q == wlast);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_i.restart) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (col_q == wlast) begin
        col_d = '0;
        row_d = (row_q == hlast) ? '0 : row_q + rbf_pkg::PosW'(1);
      end else begin
        col_d = col_q + rbf_pkg::PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      f1_valid_q <= 1'b0;
      cs_q[0]    <= '0;
      cs_q[1]    <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (accept) begin
        f1_valid_q <= 1'b1;
      end else if (f1_adv) begin
        f1_valid_q <= 1'b0;
      end
      if (f1_adv) begin
        cs_q[0] <= cs_now;
        cs_q[1] <= cs_q[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f1_px_q   <= in_px_i;
      f1_col_q  <= col_q;
      f1_row_q  <= row_q;
      f1_filt_q <= filt_now;
      f1_bord_q <= bord_now;
    end
  end

  // Line buffers: read at accept, rewritten at the same column when the front-end word advances.
  // Consecutive reads never hit the column being rewritten since rows are at least 3 wide.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= lb_mem[col_q[rbf_pkg::LbAddrW-1:0]];
    end
    if (f1_adv) begin
      lb_mem[f1_col_q[rbf_pkg::LbAddrW-1:0]] <= '{one_back: f1_px_q, two_back: rd_q.one_back};
    end
  end

  assign cs_now = rbf_pkg::col_sum(rd_q.two_back, rd_q.one_back, f1_px_q);

  always_comb begin
    push_data_o.sum  = rbf_pkg::win_sum(cs_now, cs_q[0], cs_q[1]);
    push_data_o.px   = f1_px_q;
    push_data_o.row  = f1_row_q;
    push_data_o.col  = f1_col_q;
    push_data_o.filt = f1_filt_q;
    push_data_o.bord = f1_bord_q;
  end

endmodule

`default_nettype wire

FILE: hdl/rbf_queue.sv
// Short word queue between the front end and the back end.
`default_nettype none

module rbf_queue (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_valid_i,
  output logic               push_ready_o,
  input  rbf_pkg::qentry_t   push_data_i,
  output logic               pop_valid_o,
  input  wire                pop_ready_i,
  output rbf_pkg::qentry_t   pop_data_o
);

  rbf_pkg::qentry_t          mem_q [rbf_pkg::QDepth];
  logic [rbf_pkg::QPtrW-1:0] wr_q, rd_q;
  logic [rbf_pkg::QPtrW:0]   cnt_q;
  logic                      push, pop;

  assign push_ready_o = (cnt_q < (rbf_pkg::QPtrW+1)'(rbf_pkg::QDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + rbf_pkg::QPtrW'(1);
      end
      if (pop) begin
        rd_q <= rd_q + rbf_pkg::QPtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + (rbf_pkg::QPtrW+1)'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - (rbf_pkg::QPtrW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/rbf_back.sv
// Back end: divides window sums by nine and emits filtered and border words.
`default_nettype none

module rbf_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  pop_valid_i,
  output logic                 pop_ready_o,
  input  rbf_pkg::qentry_t     pop_data_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output rbf_pkg::out_word_t   out_data_o,
  output logic                 out_last_o
);

  logic               out_valid_q;
  rbf_pkg::out_word_t out_data_q, out_data_d;
  logic               out_last_q, out_last_d;
  logic               phase_q, phase_d;
  logic               load, send_filt;
  rbf_pkg::pixel_t    mean_px;

  assign load      = ~out_valid_q | out_ready_i;
  // An entry with both results sends the filtered center first, then the border pixel.
  assign send_filt = pop_data_i.filt & ~phase_q;

  assign mean_px.red   = rbf_pkg::div9(pop_data_i.sum.red);
  assign mean_px.green = rbf_pkg::div9(pop_data_i.sum.green);
  assign mean_px.blue  = rbf_pkg::div9(pop_data_i.sum.blue);

  always_comb begin
    phase_d     = phase_q;
    pop_ready_o = 1'b0;
    if (send_filt) begin
      out_data_d.px  = mean_px;
      out_data_d.row = pop_data_i.row - rbf_pkg::PosW'(1);
      out_data_d.col = pop_data_i.col - rbf_pkg::PosW'(1);
      out_last_d     = ~pop_data_i.bord;
    end else begin
      out_data_d.px  = pop_data_i.px;
      out_data_d.row = pop_data_i.row;
      out_data_d.col = pop_data_i.col;
      out_last_d     = 1'b1;
    end
    if (load && pop_valid_i) begin
      if (send_filt && pop_data_i.bord) begin
        phase_d = 1'b1;
      end else begin
        phase_d     = 1'b0;
        pop_ready_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (load) begin
        out_valid_q <= pop_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && pop_valid_i) begin
      out_data_q <= out_data_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

FILE: test/rgb_box_filter_3x3_tb.sv
// Self-checking testbench of the RGB 3x3 box filter with a line-buffer prediction of every word.
`timescale 1ns / 100ps

module rgb_box_filter_3x3_tb;

  localparam int unsigned CLK_PERIOD    = 4;
  localparam int unsigned RESET_CYCLES  = 8;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT   = 200_000;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam int unsigned MAX_GAP       = 15;
  localparam int unsigned WIN_TAPS      = 9;
  localparam int unsigned SEND_SIDE     = 0;
  localparam int unsigned RECV_SIDE     = 1;

  typedef struct packed {
    logic [rbf_pkg::ChanW-1:0] red;
    logic [rbf_pkg::ChanW-1:0] green;
    logic [rbf_pkg::ChanW-1:0] blue;
    logic [rbf_pkg::PosW-1:0]  row;
    logic [rbf_pkg::PosW-1:0]  col;
    logic                      last;
  } filt_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i = '0;   // red_in, green_in, blue_in
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [47:0] m_axis_tdata_o;        // red_out, green_out, blue_out, out_row, out_col
  logic        m_axis_tlast_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = rbf_pkg::CFG_WIDTH;
  logic [12:0] cfg_data_i = '0;

  rgb_box_filter_3x3 uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Filter state as the block should hold it.
  rbf_pkg::pixel_t two_back_mem [rbf_pkg::MaxWidth];
  rbf_pkg::pixel_t one_back_mem [rbf_pkg::MaxWidth];
  rbf_pkg::pixel_t window [6];
  int unsigned     row_pos;
  int unsigned     col_pos;
  int unsigned     frame_width;
  int unsigned     frame_height;

  filt_word_t      due_words [$];
  rbf_pkg::pixel_t send_q [$];
  int unsigned     pixels_queued;
  int unsigned     pixels_taken;
  int unsigned     mismatches;
  int unsigned     cycle_count;
  int unsigned     send_wait;
  int unsigned     recv_wait;
  int unsigned     burst_left [2];

  function automatic rbf_pkg::pixel_t make_pixel(input logic [7:0] r, input logic [7:0] g,
                                                 input logic [7:0] b);
    rbf_pkg::pixel_t p;
    p.red   = r;
    p.green = g;
    p.blue  = b;
    return p;
  endfunction

  // Channels lean toward the extremes so that full-scale sums come up often.
  function automatic rbf_pkg::pixel_t random_pixel();
    logic [7:0] ch [3];
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(0, 7))
        0: ch[i] = 8'h00;
        1: ch[i] = 8'hFF;
        default: ch[i] = 8'($urandom);
      endcase
    end
    return make_pixel(ch[0], ch[1], ch[2]);
  endfunction

  // Mostly random waits bounded by MAX_GAP, with occasional stretches of back-to-back words.
  function automatic int unsigned draw_gap(input int unsigned side);
    int unsigned gap;
    if (burst_left[side] > 0) begin
      burst_left[side]--;
      gap = 0;
    end else if ($urandom_range(0, 15) == 0) begin
      burst_left[side] = $urandom_range(10, 40);
      gap = 0;
    end else begin
      gap = $urandom_range(0, MAX_GAP);
    end
    return gap;
  endfunction

  function automatic void set_frame_dim(input rbf_pkg::cfg_reg_e idx,
                                        input logic [12:0] value);
    int unsigned v;
    int unsigned hi;
    v  = value;
    hi = (idx == rbf_pkg::CFG_WIDTH) ? rbf_pkg::WidthMax : rbf_pkg::HeightMax;
    if (v < rbf_pkg::DimMin) begin
      v = rbf_pkg::DimMin;
    end else if (v > hi) begin
      v = hi;
    end
    if (idx == rbf_pkg::CFG_WIDTH) begin
      frame_width = v;
    end else begin
      frame_height = v;
    end
    row_pos = 0;
    col_pos = 0;
  endfunction

  // Places one pixel and queues the words it releases: the finished window center first,
  // then the pixel itself when it lies on the frame border.
  function automatic void box_filter_pixel(input rbf_pkg::pixel_t px);
    rbf_pkg::pixel_t top;
    rbf_pkg::pixel_t mid;
    int unsigned     r;
    int unsigned     c;
    int unsigned     sum_r;
    int unsigned     sum_g;
    int unsigned     sum_b;
    bit              on_border;
    filt_word_t      w;
    r = row_pos;
    c = col_pos;
    top = two_back_mem[c];
    mid = one_back_mem[c];
    on_border = (r == 0) || (r == frame_height - 1) || (c == 0) || (c == frame_width - 1);
    if (r >= 2 && c >= 2) begin
      sum_r = top.red + mid.red + px.red;
      sum_g = top.green + mid.green + px.green;
      sum_b = top.blue + mid.blue + px.blue;
      for (int i = 0; i < 6; i++) begin
        sum_r += window[i].red;
        sum_g += window[i].green;
        sum_b += window[i].blue;
      end
      w.red   = 8'(sum_r / WIN_TAPS);
      w.green = 8'(sum_g / WIN_TAPS);
      w.blue  = 8'(sum_b / WIN_TAPS);
      w.row   = rbf_pkg::PosW'(r - 1);
      w.col   = rbf_pkg::PosW'(c - 1);
      w.last  = !on_border;
      due_words.push_back(w);
    end
    if (on_border) begin
      w.red   = px.red;
      w.green = px.green;
      w.blue  = px.blue;
      w.row   = rbf_pkg::PosW'(r);
      w.col   = rbf_pkg::PosW'(c);
      w.last  = 1'b1;
      due_words.push_back(w);
    end
    two_back_mem[c] = mid;
    one_back_mem[c] = px;
    window[3] = window[0];
    window[4] = window[1];
    window[5] = window[2];
    window[0] = top;
    window[1] = mid;
    window[2] = px;
    c++;
    if (c >= frame_width) begin
      c = 0;
      r++;
      if (r >= frame_height) begin
        r = 0;
      end
    end
    row_pos = r;
    col_pos = c;
  endfunction

  // Pixel driver: holds a word until it is taken, then waits its drawn gap before the next.
  always @(posedge clk_i) begin : pixel_driver
    bit slot_free;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        box_filter_pixel(rbf_pkg::pixel_t'(s_axis_tdata_i));
        pixels_taken++;
        send_wait = draw_gap(SEND_SIDE);
      end
      slot_free = !s_axis_tvalid_i || s_axis_tready_o;
      if (slot_free) begin
        if (send_wait > 0) begin
          send_wait--;
          s_axis_tvalid_i <= 1'b0;
        end else if (send_q.size() > 0) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= send_q.pop_front();
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each word against the oldest expectation and stalls at random.
  always @(posedge clk_i) begin : word_monitor
    filt_word_t got;
    filt_word_t want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.red   = m_axis_tdata_o[7:0];
        got.green = m_axis_tdata_o[15:8];
        got.blue  = m_axis_tdata_o[23:16];
        got.row   = m_axis_tdata_o[35:24];
        got.col   = m_axis_tdata_o[47:36];
        got.last  = m_axis_tlast_o;
        if (due_words.size() == 0) begin
          if (mismatches < REPORT_LIMIT) begin
            $display("unexpected word: rgb %h %h %h row %0d col %0d last %b",
                     got.red, got.green, got.blue, got.row, got.col, got.last);
          end
          mismatches++;
        end else begin
          want = due_words.pop_front();
          if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
              got.row !== want.row || got.col !== want.col || got.last !== want.last) begin
            if (mismatches < REPORT_LIMIT) begin
              $display("mismatch: expected rgb %h %h %h row %0d col %0d last %b",
                       want.red, want.green, want.blue, want.row, want.col, want.last);
              $display("          actual   rgb %h %h %h row %0d col %0d last %b",
                       got.red, got.green, got.blue, got.row, got.col, got.last);
            end
            mismatches++;
          end
        end
        recv_wait = draw_gap(RECV_SIDE);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  task automatic push_pixel(input rbf_pkg::pixel_t p);
    send_q.push_back(p);
    pixels_queued++;
  endtask

  // Waits until every pixel is taken and every word has come, then lets the pipeline empty,
  // since pixels inside the frame that finish no window leave nothing to wait for.
  task automatic wait_idle();
    while (pixels_taken != pixels_queued || due_words.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input rbf_pkg::cfg_reg_e idx, input logic [12:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    set_frame_dim(idx, value);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    for (int i = 0; i < rbf_pkg::MaxWidth; i++) begin
      two_back_mem[i] = '0;
      one_back_mem[i] = '0;
    end
    for (int i = 0; i < 6; i++) begin
      window[i] = '0;
    end
    row_pos      = 0;
    col_pos      = 0;
    frame_width  = rbf_pkg::WidthReset;
    frame_height = rbf_pkg::HeightReset;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Out-of-range values saturate to the smallest 3x3 frame.
    write_reg(rbf_pkg::CFG_WIDTH, 13'd0);
    write_reg(rbf_pkg::CFG_HEIGHT, 13'd2);
    repeat (9) push_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF));
    repeat (9) push_pixel('0);
    push_pixel(make_pixel(8'h01, 8'h80, 8'hFE));
    push_pixel(make_pixel(8'h7F, 8'h00, 8'hFF));
    push_pixel(make_pixel(8'hAA, 8'h55, 8'h0F));
    push_pixel(make_pixel(8'h10, 8'hF0, 8'h3C));
    push_pixel(make_pixel(8'hFF, 8'h00, 8'h81));
    push_pixel(make_pixel(8'h00, 8'hFF, 8'h7E));
    push_pixel(make_pixel(8'h5A, 8'hC3, 8'h24));
    wait_idle();

    // Small random frames; the previous frame is left unfinished, so each write restarts it.
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(rbf_pkg::CFG_WIDTH, 13'($urandom_range(3, 5)));
      write_reg(rbf_pkg::CFG_HEIGHT, 13'($urandom_range(3, 5)));
      for (int i = 0; i < 14; i++) begin
        push_pixel(random_pixel());
        if (ph == 0 && i == 6) begin
          wait_idle();
        end
      end
      wait_idle();
    end

    // Tallest frame, saturated from an all-ones value, on the narrowest rows.
    write_reg(rbf_pkg::CFG_HEIGHT, 13'h1FFF);
    write_reg(rbf_pkg::CFG_WIDTH, 13'd3);
    repeat (12) push_pixel(random_pixel());
    wait_idle();

    // Widest rows, saturated from an all-ones value; the start of the first row passes through.
    write_reg(rbf_pkg::CFG_HEIGHT, 13'd3);
    write_reg(rbf_pkg::CFG_WIDTH, 13'h1FFF);
    repeat (8) push_pixel(random_pixel());
    wait_idle();

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
